@@ hdl/mslc_pkg.sv @@
// ----------------------------------------------------------------------------
// mslc_pkg
// Shared types and constants for the microphone sample and level capture block.
// ----------------------------------------------------------------------------
package mslc_pkg;

    localparam int RAW_W      = 32;
    localparam int SMP_W      = 16;
    localparam int CFG_W      = 21;
    localparam int ADDR_W     = 20;
    localparam int LVL_W      = 16;
    localparam int QUO_W      = 32;   // mean of squares, padded to whole bit pairs
    localparam int ROOT_STEPS = QUO_W / 2;
    localparam int M_DATA_W   = 56;
    localparam int M_DATA_PAD = M_DATA_W - SMP_W - ADDR_W - LVL_W;

    localparam int CHUNK_MAX_DEF     = 512;
    localparam int BUFFER_FRAMES_DEF = 1048576;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1048576);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_START,
        ST_WAIT,
        ST_OUT
    } mslc_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT,
        U_DONE
    } mslc_ustate_t;

    typedef struct packed {
        logic start;
    } mslc_req_t;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] level;
    } mslc_sts_t;

endpackage

@@ hdl/mic_sample_level_capture.sv @@
// ----------------------------------------------------------------------------
// mic_sample_level_capture
// Microphone sample path with capture buffer addressing and chunked RMS meter.
// ----------------------------------------------------------------------------
// Each request on the slave side is one raw 32-bit slot (s_tlast marks the
// end of a level chunk) and gives exactly one result: the top 16 bits as a
// signed sample, a capture buffer address while room remains, and the level.
// An ordinary sample passes through ST_ACC and ST_OUT to the output register,
// and the next request is taken only once that sample is loaded there.
// A sample that closes a chunk also runs the level calculator, which shares
// one subtractor between a restoring divider (SUM_W steps, SUM_W =
// 32 + clog2(CHUNK_MAX)) and a 16-step square root, and such a sample passes
// through ST_ACC, ST_START, ST_WAIT and ST_OUT to the output register; here
// too the next request is taken only once that sample is loaded there.
// s_tready is low while an item is in work; the output register lets the
// next request be taken while a result still waits on m_tready.
// ----------------------------------------------------------------------------
module mic_sample_level_capture import mslc_pkg::*; #(
    parameter int CHUNK_MAX     = CHUNK_MAX_DEF,
    parameter int BUFFER_FRAMES = BUFFER_FRAMES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,   // buffer capacity in samples
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [RAW_W-1:0]    s_tdata,       // [31:0] raw_slot
    input  logic                s_tlast,       // chunk_end
    output logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] sample_out, [35:16] buffer_addr, [51:36] level_rms, [55:52] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser,       // [0] buffer_write
    output logic                m_tlast        // level_valid
);

    localparam int CNT_W = $clog2(CHUNK_MAX + 1);
    localparam int SUM_W = 32 + $clog2(CHUNK_MAX);
    localparam int BUF_W = $clog2(BUFFER_FRAMES + 1);
    localparam int CMP_W = (BUF_W > CFG_W) ? BUF_W : CFG_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CHUNK_MAX);
    localparam logic [CMP_W-1:0] BUF_LIMIT = CMP_W'(BUFFER_FRAMES);

    mslc_state_t        state_reg, state_next;
    logic [CFG_W-1:0]   cap_reg;
    logic [CFG_W-1:0]   wpos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LVL_W-1:0]   level_reg;
    logic [SMP_W-1:0]   sample_reg;
    logic [2*SMP_W-1:0] sq_reg;
    logic               last_reg;
    logic               wr_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               lvl_new_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic               m_user_reg;
    logic               m_last_reg;

    logic               accept;
    logic               out_free;
    logic [CNT_W-1:0]   count_inc;
    logic               chunk_done;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               room;
    logic signed [SMP_W-1:0] in_sample;
    mslc_req_t          unit_req;
    mslc_sts_t          unit_sts;

    assign in_sample  = s_tdata[RAW_W-1 -: SMP_W];
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign count_inc  = count_reg + 1'b1;
    assign chunk_done = last_reg || (count_inc >= CNT_LIMIT);
    assign cap_ext    = CMP_W'(cap_reg);
    assign eff_cap    = (cap_ext > BUF_LIMIT) ? BUF_LIMIT : cap_ext;
    assign room       = (CMP_W'(wpos_reg) < eff_cap);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ACC;
            ST_ACC:   state_next = chunk_done ? ST_START : ST_OUT;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (unit_sts.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == ST_IDLE) && aresetn;
        unit_req.start = (state_reg == ST_START);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            wpos_reg     <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            level_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept && room) begin
                wpos_reg <= wpos_reg + 1'b1;
            end
            if (state_reg == ST_ACC) begin
                sum_reg   <= sum_reg + SUM_W'(sq_reg);
                count_reg <= count_inc;
            end
            if (state_reg == ST_WAIT && unit_sts.done) begin
                level_reg <= unit_sts.level;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg  <= in_sample;
            sq_reg      <= (2*SMP_W)'(in_sample * in_sample);
            last_reg    <= s_tlast;
            wr_reg      <= room;
            addr_reg    <= room ? wpos_reg[ADDR_W-1:0] : '0;
            lvl_new_reg <= 1'b0;
        end
        if (state_reg == ST_WAIT && unit_sts.done) begin
            lvl_new_reg <= 1'b1;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= {{M_DATA_PAD{1'b0}}, level_reg, addr_reg, sample_reg};
            m_user_reg <= wr_reg;
            m_last_reg <= lvl_new_reg;
        end
    end

    mslc_root_unit #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .sum     (sum_reg),
        .count   (count_reg),
        .sts     (unit_sts)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule

@@ hdl/mslc_root_unit.sv @@
// ----------------------------------------------------------------------------
// mslc_root_unit
// Level calculator: restoring division of the chunk sum by the sample count,
// then a digit-by-digit integer square root, both on one shared subtractor.
// ----------------------------------------------------------------------------
module mslc_root_unit import mslc_pkg::*; #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mslc_req_t        req,
    input  logic [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0] count,
    output mslc_sts_t        sts
);

    localparam int SUB_W  = (CNT_W + 1 > LVL_W + 3) ? CNT_W + 1 : LVL_W + 3;
    localparam int STEP_W = $clog2(SUM_W);

    mslc_ustate_t      state_reg, state_next;
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [SUB_W-1:0]  rem_reg;
    logic [LVL_W-1:0]  root_reg;
    logic [STEP_W-1:0] step_reg;

    logic [SUB_W-1:0]  op_a;
    logic [SUB_W-1:0]  op_b;
    logic [SUB_W:0]    diff;
    logic              ge;

    // shared subtract/compare
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            U_DIV: begin
                op_a = SUB_W'({rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]});
                op_b = SUB_W'(den_reg);
            end
            U_SQRT: begin
                op_a = SUB_W'({rem_reg[LVL_W:0], dvd_reg[QUO_W-1 -: 2]});
                op_b = SUB_W'({root_reg[LVL_W-2:0], 2'b01});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[SUB_W];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE: if (req.start) state_next = U_DIV;
            U_DIV:  if (step_reg == '0) state_next = U_SQRT;
            U_SQRT: if (step_reg == '0) state_next = U_DONE;
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_comb begin
        sts.done  = (state_reg == U_DONE);
        sts.level = root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    dvd_reg  <= sum;
                    den_reg  <= count;
                    rem_reg  <= '0;
                    step_reg <= STEP_W'(SUM_W - 1);
                end
            end
            U_DIV: begin
                // quotient bits shift in as the dividend shifts out
                dvd_reg <= {dvd_reg[SUM_W-2:0], ge};
                if (step_reg == '0) begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= STEP_W'(ROOT_STEPS - 1);
                end else begin
                    rem_reg  <= ge ? diff[SUB_W-1:0] : op_a;
                    step_reg <= step_reg - 1'b1;
                end
            end
            U_SQRT: begin
                dvd_reg  <= {dvd_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= ge ? diff[SUB_W-1:0] : op_a;
                root_reg <= {root_reg[LVL_W-2:0], ge};
                step_reg <= step_reg - 1'b1;
            end
            default: begin
                rem_reg <= rem_reg;
            end
        endcase
    end

endmodule

@@ hdl/mslc_checker.sv @@
// ----------------------------------------------------------------------------
// mslc_checker
// Port-level checks for the sample and level capture block.
// ----------------------------------------------------------------------------
module mslc_checker import mslc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser,
    input logic                m_tlast
);

    logic [LVL_W-1:0] prev_lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_lvl_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            prev_lvl_reg <= m_tdata[51:36];
        end
    end

    // one request at a time: the block is busy right after taking one
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous still in work");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[35:16] == '0)
        else $error("address set on a sample that was not stored");

    // level only moves on a result that closes a chunk
    a_level_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[51:36] == prev_lvl_reg)
        else $error("level changed without chunk end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind mic_sample_level_capture mslc_checker u_mslc_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streaming testbench for the microphone sample and level capture block.
// A queue of raw slots feeds a burst/gap driver on the slave side, and the
// master side stalls on a shifting ready pattern with one long hold-off. Each
// accepted request is run through a local model of the sample path, buffer
// addressing and chunk RMS meter, and every result is checked field by field.
// The capacity register is swept over several settings between phases.
// ----------------------------------------------------------------------------
module tb_top import mslc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 3000;
    localparam int SETTLE     = 80;
    localparam int LONG_HOLD  = 500;

    typedef struct {
        logic [RAW_W-1:0] raw;
        logic             chunk_end;
    } slot_req_t;

    typedef struct {
        logic [SMP_W-1:0]  sample;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic              lvl_new;
        logic [LVL_W-1:0]  level;
    } meter_out_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [RAW_W-1:0]    s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;

    // local copy of the block's state
    logic [CFG_W-1:0] cap_frames;
    logic [63:0]      sq_sum;
    int unsigned      chunk_cnt;
    logic [CFG_W-1:0] wpos;
    logic [LVL_W-1:0] last_lvl;

    slot_req_t  slot_queue[$];
    meter_out_t due_results[$];

    int fail_cnt     = 0;
    int results_seen = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_cnt     = 0;
    bit long_hold_due = 1'b1;
    int ready_pct    = 100;
    int window_cnt   = 0;
    int idle_cycles  = 0;

    mic_sample_level_capture dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [LVL_W-1:0] floor_sqrt(input logic [63:0] v);
        logic [16:0] r;
        logic [16:0] t;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (17'(1) << b);
            if (64'(t) * 64'(t) <= v)
                r = t;
        end
        return r[LVL_W-1:0];
    endfunction

    function automatic meter_out_t meter_predict(input slot_req_t req);
        meter_out_t       res;
        logic signed [31:0] smp;
        logic [CFG_W-1:0] eff_cap;
        smp = 32'(signed'(req.raw[31:16]));
        res.sample = req.raw[31:16];
        eff_cap = (cap_frames > CFG_W'(BUFFER_FRAMES_DEF)) ?
                  CFG_W'(BUFFER_FRAMES_DEF) : cap_frames;
        res.wr   = 1'b0;
        res.addr = '0;
        if (wpos < eff_cap) begin
            res.wr   = 1'b1;
            res.addr = wpos[ADDR_W-1:0];
            wpos     = wpos + 1'b1;
        end
        sq_sum    = sq_sum + 64'(smp * smp);
        chunk_cnt = chunk_cnt + 1;
        res.lvl_new = 1'b0;
        if (req.chunk_end || chunk_cnt >= CHUNK_MAX_DEF) begin
            last_lvl    = floor_sqrt(sq_sum / 64'(chunk_cnt));
            res.lvl_new = 1'b1;
            sq_sum      = '0;
            chunk_cnt   = 0;
        end
        res.level = last_lvl;
        return res;
    endfunction

    // driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        slot_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(meter_predict('{raw: s_tdata, chunk_end: s_tlast}));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (slot_queue.size() > 0) begin
                    nxt = slot_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.raw;
                    s_tlast  <= nxt.chunk_end;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random ready rate redrawn each time window_cnt wraps, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (long_hold_due && results_seen >= 100) begin
            long_hold_due = 1'b0;
            hold_cnt <= LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (window_cnt == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    ready_pct = 100;
                    2:       ready_pct = 70;
                    default: ready_pct = 25;
                endcase
            end
            window_cnt <= (window_cnt + 1) % 64;
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        meter_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding: m_tdata %h", m_tdata);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                if (m_tdata[15:0] !== want.sample) begin
                    $error("sample_out: expected %h, got %h", want.sample, m_tdata[15:0]);
                    fail_cnt++;
                end
                if (m_tuser[0] !== want.wr) begin
                    $error("buffer_write: expected %0d, got %0d", want.wr, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tdata[35:16] !== want.addr) begin
                    $error("buffer_addr: expected %0d, got %0d", want.addr, m_tdata[35:16]);
                    fail_cnt++;
                end
                if (m_tlast !== want.lvl_new) begin
                    $error("level_valid: expected %0d, got %0d", want.lvl_new, m_tlast);
                    fail_cnt++;
                end
                if (m_tdata[51:36] !== want.level) begin
                    $error("level_rms: expected %0d, got %0d", want.level, m_tdata[51:36]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_capacity(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_frames = v;
    endtask

    task automatic wait_idle();
        while (slot_queue.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic add_slot(input logic [RAW_W-1:0] raw, input logic chunk_end);
        slot_queue.push_back('{raw: raw, chunk_end: chunk_end});
    endtask

    function automatic logic [RAW_W-1:0] rand_raw();
        logic [15:0] amp;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000 | 32'($urandom_range(0, 16'hFFFF));
                endcase
            end
            1, 2: begin
                // quiet signal around zero
                amp = 16'($urandom_range(0, 400)) - 16'd200;
                return {amp, 16'($urandom)};
            end
            default: return $urandom;
        endcase
    endfunction

    // well-formed chunks of random length; the last one is always closed
    task automatic add_chunks(input int n);
        int len;
        len = 0;
        for (int i = 0; i < n; i++) begin
            if (len == 0)
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            len--;
            add_slot(rand_raw(), (len == 0) || (i == n - 1));
            if (i == n - 1)
                len = 0;
        end
    endtask

    initial begin
        cap_frames = CAP_RESET;
        sq_sum     = '0;
        chunk_cnt  = 0;
        wpos       = '0;
        last_lvl   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, one-sample chunks, longer mixed chunks
        add_slot(32'h8000_0000, 1'b1);
        add_slot(32'h7FFF_FFFF, 1'b1);
        add_slot(32'h0000_FFFF, 1'b1);
        add_slot(32'hFFFF_FFFF, 1'b1);
        add_slot(32'h0001_0000, 1'b1);
        add_slot(32'h0000_0000, 1'b0);
        add_slot(32'h8000_0000, 1'b0);
        add_slot(32'h7FFF_0000, 1'b0);
        add_slot(32'hFFFF_0000, 1'b1);
        add_slot(32'h1234_5678, 1'b0);
        add_slot(32'hEDCB_A987, 1'b0);
        add_slot(32'h5555_AAAA, 1'b0);
        add_slot(32'hAAAA_5555, 1'b1);
        add_slot(32'h0003_0000, 1'b0);
        add_slot(32'h0004_0000, 1'b1);
        add_slot(32'hFFFE_0000, 1'b1);
        wait_idle();

        // nothing stored at zero capacity
        write_capacity('0);
        add_chunks(40);
        wait_idle();

        // more slots than fit: storing resumes from the kept position
        write_capacity(wpos + CFG_W'(12));
        add_chunks(40);
        wait_idle();

        // capacity beyond the buffer size; a long unmarked run hits the chunk limit
        write_capacity({CFG_W{1'b1}});
        for (int i = 0; i < CHUNK_MAX_DEF + 8; i++)
            add_slot(rand_raw(), 1'b0);
        add_chunks(30);
        wait_idle();

        // capacity lowered below the write position
        write_capacity(CFG_W'(3));
        add_chunks(60);
        wait_idle();

        write_capacity(CAP_RESET);
        add_chunks(60);
        wait_idle();

        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
